FILE: hw/rtl/dtti_pkg.sv
// Shared types and constants for the decimal text to integer parser.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package dtti_pkg;

  // Default width of the signed result.
  localparam int unsigned RESULT_BITS_DEFAULT = 32;

  // Depth of the queue between the classifier and the accumulator.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Class of one input byte.
  typedef enum logic [2:0] {
    KIND_TERM,
    KIND_BLANK,
    KIND_PLUS,
    KIND_MINUS,
    KIND_DIGIT,
    KIND_OTHER
  } kind_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
  } entry_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_DIGITS = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/decimal_text_to_int_parser_top.sv
// Top level of the decimal text to integer parser.
// Depends on dtti_pkg, dtti_front, dtti_queue and dtti_back.
//
//   Channel  Handshake            Payload
//   input    in_valid / in_stall  ch (8 bits, one byte, zero ends a string)
//   output   out_valid/out_stall  value (RESULT_BITS, signed), status (2)
//
// One byte is taken every cycle while in_stall is low; the accumulator does its
// multiply by ten, add and range compare combinationally, which sets that rate.
// A terminating byte passes through the queue first; its result is registered
// once the byte reaches the queue head and the result register is free.
// Reset is synchronous and clears the parser, the queue and the result valid.
// A stalled result only holds back terminators; other bytes keep flowing
// until the two-entry queue fills, and then in_stall rises.
`default_nettype none

module decimal_text_to_int_parser_top #(
  parameter int unsigned RESULT_BITS = dtti_pkg::RESULT_BITS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [7:0]               ch,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [RESULT_BITS-1:0] value,
  output logic [1:0]                    status
);
  import dtti_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   q_valid;
  entry_t q_entry;
  logic   pop;

  // Byte classification.
  dtti_front u_front (
    .in_valid   (in_valid),
    .ch         (ch),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decoupling queue.
  dtti_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  // Parser and result register.
  dtti_back #(
    .RESULT_BITS (RESULT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
  );

  // Any failed parse reports a zero value.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |-> (value == '0))
    else $error("non-zero value with a failure status");

  // A terminator at the queue head with a free result register is emitted.
  assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_entry.kind == KIND_TERM && !(out_valid && out_stall)) |=> out_valid)
    else $error("terminator taken but no result presented");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

FILE: hw/rtl/dtti_front.sv
// Front end: takes input bytes and classifies each into a queue entry.
// Depends on dtti_pkg.
`default_nettype none

module dtti_front (
  input  wire logic            in_valid,
  input  wire logic [7:0]      ch,
  input  wire logic            q_full,
  output logic                 in_stall,
  output logic                 push,
  output dtti_pkg::entry_t     push_entry
);
  import dtti_pkg::*;

  // Hold the sender off while the queue has no room.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Sort the byte into terminator, whitespace, sign, digit or anything else.
  always_comb begin
    push_entry.digit = ch[3:0];
    if (ch == CH_NUL) begin
      push_entry.kind = KIND_TERM;
    end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_LF ||
                 ch == CH_VT || ch == CH_FF || ch == CH_CR) begin
      push_entry.kind = KIND_BLANK;
    end else if (ch == CH_PLUS) begin
      push_entry.kind = KIND_PLUS;
    end else if (ch == CH_MINUS) begin
      push_entry.kind = KIND_MINUS;
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      push_entry.kind = KIND_DIGIT;
    end else begin
      push_entry.kind = KIND_OTHER;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dtti_queue.sv
// Short first-in first-out queue of classified items.
// Depends on dtti_pkg for the entry type and depth.
`default_nettype none

module dtti_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire dtti_pkg::entry_t  push_entry,
  input  wire logic              pop,
  output logic                   full,
  output logic                   q_valid,
  output dtti_pkg::entry_t       q_entry
);
  import dtti_pkg::*;

  entry_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = entries[rd_ptr];
  assign do_pop  = pop && q_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dtti_back.sv
// Back end: runs the parse state machine, accumulates digits and
// holds the result register. Depends on dtti_pkg.
`default_nettype none

module dtti_back #(
  parameter int unsigned RESULT_BITS = dtti_pkg::RESULT_BITS_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_valid,
  input  wire dtti_pkg::entry_t        q_entry,
  output logic                         pop,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [RESULT_BITS-1:0] value,
  output logic [1:0]                   status
);
  import dtti_pkg::*;

  localparam int unsigned PW = RESULT_BITS + 4;
  localparam logic [PW-1:0] NEG_LIMIT = PW'(1) << (RESULT_BITS - 1);
  localparam logic [PW-1:0] POS_LIMIT = NEG_LIMIT - PW'(1);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_READ,
    PH_STOP
  } phase_t;

  phase_t                 phase, phase_next;
  logic                   negative, negative_next;
  logic [RESULT_BITS-1:0] acc, acc_next;
  logic                   digit_seen, digit_seen_next;
  logic                   overflowed, overflowed_next;

  logic                   out_free;
  logic                   is_term;
  logic                   emit;
  logic [PW-1:0]          prod;
  logic [PW-1:0]          limit;
  logic                   too_big;
  logic [RESULT_BITS-1:0] result_mag;

  // A terminator needs the result register free; anything else goes at once.
  assign out_free = !out_valid || !out_stall;
  assign is_term  = (q_entry.kind == KIND_TERM);
  assign pop      = q_valid && (!is_term || out_free);
  assign emit     = pop && is_term;

  // Times ten plus the digit, checked against the signed range.
  assign prod    = (PW'(acc) << 3) + (PW'(acc) << 1) + PW'(q_entry.digit);
  assign limit   = negative ? NEG_LIMIT : POS_LIMIT;
  assign too_big = (prod > limit);

  assign result_mag = negative ? (RESULT_BITS'(0) - acc) : acc;

  // Next state of the parser.
  always_comb begin
    phase_next      = phase;
    negative_next   = negative;
    acc_next        = acc;
    digit_seen_next = digit_seen;
    overflowed_next = overflowed;
    if (pop) begin
      if (is_term) begin
        phase_next      = PH_SKIP;
        negative_next   = 1'b0;
        acc_next        = '0;
        digit_seen_next = 1'b0;
        overflowed_next = 1'b0;
      end else begin
        case (phase)
          PH_SKIP, PH_READ: begin
            if (q_entry.kind == KIND_DIGIT) begin
              digit_seen_next = 1'b1;
              if (too_big) begin
                overflowed_next = 1'b1;
                phase_next      = PH_STOP;
              end else begin
                acc_next   = prod[RESULT_BITS-1:0];
                phase_next = PH_READ;
              end
            end else if (phase == PH_SKIP && q_entry.kind == KIND_BLANK) begin
              phase_next = PH_SKIP;
            end else if (phase == PH_SKIP &&
                         (q_entry.kind == KIND_PLUS || q_entry.kind == KIND_MINUS)) begin
              negative_next = (q_entry.kind == KIND_MINUS);
              phase_next    = PH_READ;
            end else begin
              phase_next = PH_STOP;
            end
          end
          default: begin
            phase_next = PH_STOP;
          end
        endcase
      end
    end
  end

  // State and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SKIP;
      negative   <= 1'b0;
      acc        <= '0;
      digit_seen <= 1'b0;
      overflowed <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      negative   <= negative_next;
      acc        <= acc_next;
      digit_seen <= digit_seen_next;
      overflowed <= overflowed_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded when a terminator is taken.
  always_ff @(posedge clk) begin
    if (emit) begin
      if (overflowed) begin
        value  <= '0;
        status <= STATUS_OVERFLOW;
      end else if (!digit_seen) begin
        value  <= '0;
        status <= STATUS_NO_DIGITS;
      end else begin
        value  <= result_mag;
        status <= STATUS_OK;
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/decimal_text_to_int_parser_top_test.sv
// Self-checking testbench for the decimal text to integer parser top level.
// Depends on dtti_pkg and decimal_text_to_int_parser_top; strings are fed one byte per item
// and every parsed value and status is compared with a behavioural prediction.
`default_nettype none

module decimal_text_to_int_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dtti_pkg::*;

  localparam int RES_BITS    = RESULT_BITS_DEFAULT;
  localparam int BYTE_TARGET = 1550;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_GAP     = 18;

  // Idle patterns for both channels.
  typedef enum int {IDLE_NONE, IDLE_ANY, IDLE_RARE} idle_mode_t;

  // Predicts the parser's results and checks what comes out of it.
  class int_parse_scoreboard;
    typedef enum logic [1:0] {SKIP_BLANKS, READ_DIGITS, IGNORE_REST} scan_t;

    scan_t       scan;
    bit          negative;
    bit [63:0]   magnitude;
    bit          digit_seen;
    bit          overflowed;
    logic signed [RES_BITS-1:0] want_value[$];
    status_t     want_status[$];
    int          mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      scan       = SKIP_BLANKS;
      negative   = 1'b0;
      magnitude  = '0;
      digit_seen = 1'b0;
      overflowed = 1'b0;
    endfunction

    function int pending();
      return want_status.size();
    endfunction

    // A digit that would push the magnitude past the signed range stops the scan.
    function void take_digit(logic [7:0] c);
      bit [63:0] d;
      bit [63:0] limit;
      d     = 64'(c - CH_ZERO);
      limit = negative ? (64'd1 << (RES_BITS - 1)) : ((64'd1 << (RES_BITS - 1)) - 64'd1);
      digit_seen = 1'b1;
      if (magnitude > (limit - d) / 64'd10) begin
        overflowed = 1'b1;
        scan       = IGNORE_REST;
      end else begin
        magnitude = magnitude * 64'd10 + d;
        scan      = READ_DIGITS;
      end
    endfunction

    // Notes one accepted item; a terminator queues the expected result.
    function void note_byte(logic [7:0] c);
      logic [RES_BITS-1:0] v;
      status_t             st;
      if (c == CH_NUL) begin
        v = '0;
        if (overflowed) begin
          st = STATUS_OVERFLOW;
        end else if (!digit_seen) begin
          st = STATUS_NO_DIGITS;
        end else begin
          st = STATUS_OK;
          v  = magnitude[RES_BITS-1:0];
          if (negative) begin
            v = -v;
          end
        end
        want_value.push_back(v);
        want_status.push_back(st);
        clear();
      end else if (scan == SKIP_BLANKS) begin
        if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) begin
          // Leading whitespace is skipped.
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          negative = (c == CH_MINUS);
          scan     = READ_DIGITS;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
          take_digit(c);
        end else begin
          scan = IGNORE_REST;
        end
      end else if (scan == READ_DIGITS) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          take_digit(c);
        end else begin
          scan = IGNORE_REST;
        end
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("%0t ns: %s", $time, msg);
    endtask

    // Compares one accepted result with the oldest expectation.
    task check_result(logic signed [RES_BITS-1:0] v, logic [1:0] st);
      logic signed [RES_BITS-1:0] ev;
      status_t                    es;
      if (want_status.size() == 0) begin
        report_mismatch($sformatf("unexpected result: value %0d status %0d", v, st));
      end else begin
        ev = want_value.pop_front();
        es = want_status.pop_front();
        if (v !== ev) begin
          report_mismatch($sformatf("value is %0d, expected %0d", v, ev));
        end
        if (st !== es) begin
          report_mismatch($sformatf("status is %0d, expected %0d", st, es));
        end
      end
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 ch = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [RES_BITS-1:0] value;
  logic [1:0]                 status;

  int_parse_scoreboard sb = new();
  logic [7:0]          text_q[$];
  int                  bytes_sent = 0;
  int                  cycle_count = 0;
  idle_mode_t          send_mode = IDLE_NONE;
  idle_mode_t          recv_mode = IDLE_ANY;

  decimal_text_to_int_parser_top #(
    .RESULT_BITS(RES_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ch       (ch),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value    (value),
    .status   (status)
  );

  // Clock generation.
  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Draws the idle cycles before one item; now and then the pattern changes.
  function automatic int draw_gap(ref idle_mode_t mode);
    if ($urandom_range(0, 59) == 0) begin
      mode = idle_mode_t'($urandom_range(0, 2));
    end
    case (mode)
      IDLE_NONE: return 0;
      IDLE_ANY:  return $urandom_range(0, MAX_GAP);
      default:   return ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_GAP) : 0;
    endcase
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
    end
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // Any byte but the terminator, biased towards the bytes the parser reacts to.
  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 4))
      0:       return CH_ZERO + 8'($urandom_range(0, 9));
      1:       return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
      2:       return pick_blank();
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Builds one random string: mostly a well-formed number, otherwise noise.
  function automatic void build_random_text();
    if ($urandom_range(0, 9) < 7) begin
      repeat ($urandom_range(0, 3)) text_q.push_back(pick_blank());
      case ($urandom_range(0, 2))
        0: text_q.push_back(CH_PLUS);
        1: text_q.push_back(CH_MINUS);
        default: ;
      endcase
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) text_q.push_back(CH_ZERO);
      end
      // Numbers around the edges of the signed range, zero, or a random run of digits.
      case ($urandom_range(0, 11))
        0:  add_text("2147483647");
        1:  add_text("2147483648");
        2:  add_text("2147483649");
        3:  add_text("4294967296");
        4:  add_text("214748364");
        5:  add_text("21474836470");
        6:  add_text("0");
        7:  add_text("999999999999");
        default: begin
          repeat ($urandom_range(1, 10)) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
      endcase
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) text_q.push_back(pick_noise());
      end
    end else begin
      repeat ($urandom_range(0, 8)) text_q.push_back(pick_noise());
    end
    text_q.push_back(CH_NUL);
  endfunction

  // Offers one item and waits until it is taken.
  task automatic send_byte(logic [7:0] c);
    int gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    sb.note_byte(c);
    bytes_sent++;
  endtask

  task automatic send_text();
    while (text_q.size() > 0) begin
      send_byte(text_q.pop_front());
    end
  endtask

  // Stops offering items and waits until every expected result has come.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.pending() != 0);
  endtask

  // Result side: stalls at random before each item, then takes it.
  initial begin
    int gap;
    wait (rst == 1'b0);
    forever begin
      gap = draw_gap(recv_mode);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(posedge clk);
      end while (out_valid !== 1'b1);
      sb.check_result(value, status);
    end
  end

  // Main sequence.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty string, sign with no digits, second sign, blank after the sign.
    text_q.push_back(CH_NUL);
    add_text("\t-");
    text_q.push_back(CH_NUL);
    add_text("+-7");
    text_q.push_back(CH_NUL);
    add_text("- 5");
    text_q.push_back(CH_NUL);
    // Minus zero, then bytes from the upper half of the range, then leading blanks before a stray letter.
    add_text("-0");
    text_q.push_back(CH_NUL);
    text_q.push_back(8'h80);
    text_q.push_back(8'hFF);
    add_text("9");
    text_q.push_back(CH_NUL);
    add_text("\v\f\r\n 4x5");
    text_q.push_back(CH_NUL);
    send_text();

    // Let everything drain before the random part.
    wait_for_results();

    while (bytes_sent < BYTE_TARGET) begin
      build_random_text();
      send_text();
      if ($urandom_range(0, 39) == 0) begin
        wait_for_results();
      end
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
